[rtl/ifp_pkg.sv]
package ifp_pkg;

  localparam int CHANNELS    = 2;
  localparam int SLOTS       = 9;
  localparam int SLOT_W      = 4;
  localparam int STORE_DEPTH = CHANNELS * SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [7:0] LEADER_RST  = 8'd160;
  localparam logic [7:0] MAC_RST     = 8'd96;
  localparam logic [7:0] PRESS_RST   = 8'd97;
  localparam logic [7:0] RELEASE_RST = 8'd98;
  localparam logic [7:0] ACK_RST     = 8'd99;

  localparam logic [7:0] SIG_A      = 8'h5F;
  localparam logic [7:0] SIG_B      = 8'hF6;
  localparam logic [7:0] SIG_C      = 8'h56;
  localparam logic [8:0] PAIR_TOTAL = 9'd255;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [2:0] REG_LEADER  = 3'd0;
  localparam logic [2:0] REG_MAC     = 3'd1;
  localparam logic [2:0] REG_PRESS   = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_ACK     = 3'd4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SIGNAL  = 3'd1;
  localparam logic [2:0] EV_ADDR    = 3'd2;
  localparam logic [2:0] EV_PRESS   = 3'd3;
  localparam logic [2:0] EV_RELEASE = 3'd4;
  localparam logic [2:0] EV_ACK     = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              clr;
    logic              take;
    logic [SLOT_W-1:0] slot;
  } acc_ctl_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic ch,
                                                  input logic [SLOT_W-1:0] slot);
    slot_addr = ADDR_W'(ch) * ADDR_W'(SLOTS) + ADDR_W'(slot);
  endfunction

endpackage

[rtl/ifp_ram.sv]
module ifp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ifp_accum.sv]
module ifp_accum (
  input  logic              clk,
  input  ifp_pkg::acc_ctl_t ctl,
  input  logic [7:0]        data,
  output logic [7:0]        b0,
  output logic [7:0]        b1,
  output logic [7:0]        b2,
  output logic [7:0]        b8,
  output logic [7:0]        sum,
  output logic [47:0]       addr
);
  import ifp_pkg::*;

  // one shared 8-bit adder walks the frame slot by slot
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      sum  <= '0;
      addr <= '0;
    end else if (ctl.take) begin
      if (ctl.slot < SLOT_W'(SLOTS - 1)) begin
        sum <= sum + data;
      end
      if (ctl.slot >= SLOT_W'(2) && ctl.slot < SLOT_W'(SLOTS - 1)) begin
        addr <= {addr[39:0], data};
      end
      case (ctl.slot)
        SLOT_W'(0):         b0 <= data;
        SLOT_W'(1):         b1 <= data;
        SLOT_W'(2):         b2 <= data;
        SLOT_W'(SLOTS - 1): b8 <= data;
        default:            ;
      endcase
    end
  end

endmodule

[rtl/ir_frame_parser.sv]
// IR frame parser, two receive channels sharing one frame store.
// Input channel (in_valid/in_ready): op, channel, rx_byte. op 0 is a received
// byte, op 1 an idle timeout that clears both write positions.
// Output channel (out_valid/out_ready): exactly one item per input item, with
// event_res, event_channel, signal_code, address and selftest_flags.
// Configuration: cfg_we/cfg_index/cfg_data write the leader and command codes;
// write only while no item is in flight.
// Timing: a byte is stored first, then slots 0..2 are read back through the
// single RAM read port and the shared adder, one slot a cycle. A byte item
// that completes an address frame reads all 9 slots instead; a timeout skips
// the store and the scan.
// The result register frees the sequencer: the next item is accepted while a
// result waits; if the receiver stalls, the following item holds in its final
// step until the result register is taken.
// Reset: synchronous, clears positions, seen flags and store valid bits (the
// store reads as zero), and restores the register reset values.
module ir_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic        channel,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic        event_channel,
  output logic [7:0]  signal_code,
  output logic [47:0] address,
  output logic [1:0]  selftest_flags,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ifp_pkg::*;

  state_t state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;

  logic [7:0] leader_byte, mac_code, press_code, release_code, ack_code;
  logic [SLOT_W-1:0] write_pos [CHANNELS];
  logic [CHANNELS-1:0] seen;
  logic [STORE_DEPTH-1:0] vld;
  logic vld_rd;

  logic op_q, ch_q, in_range_q;
  logic [7:0] byte_q;
  logic [SLOT_W-1:0] pos_q, pos_cur;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata, rd_data;
  logic [SLOT_W-1:0] rd_slot;

  acc_ctl_t ctl;
  logic [7:0] b0, b1, b2, b8, sum;
  logic [47:0] acc_addr;

  logic accept, done_go;
  logic [SLOT_W-1:0] pos_eff, pos_fin;
  logic is_sig, chk_ok, long_mac, set_seen, clr1, ld_rst;
  logic [2:0] ev;
  logic [7:0] sig;
  logic [47:0] adr;

  ifp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_data = vld_rd ? ram_rdata : 8'd0;

  ifp_accum u_accum (
    .clk  (clk),
    .ctl  (ctl),
    .data (rd_data),
    .b0   (b0),
    .b1   (b1),
    .b2   (b2),
    .b8   (b8),
    .sum  (sum),
    .addr (acc_addr)
  );

  assign accept  = in_valid && in_ready;
  assign done_go = (state == S_DONE) && (!out_valid || out_ready);
  assign pos_cur = (write_pos[ch_q] >= SLOT_W'(SLOTS)) ? '0 : write_pos[ch_q];
  assign rd_slot = (cnt < SLOT_W'(SLOTS)) ? cnt : '0;
  assign ram_raddr = slot_addr(ch_q, rd_slot);

  // frame decision
  always_comb begin
    pos_eff  = (b0 == leader_byte) ? pos_q : '0;
    is_sig   = b1 inside {SIG_A, SIG_B, SIG_C};
    chk_ok   = ({1'b0, b1} + {1'b0, b2}) == PAIR_TOTAL;
    long_mac = !is_sig && (b1 == mac_code) && (pos_eff >= SLOT_W'(SLOTS));
    ev       = EV_NONE;
    sig      = 8'd0;
    adr      = 48'd0;
    pos_fin  = pos_eff;
    set_seen = 1'b0;
    clr1     = 1'b0;
    ld_rst   = 1'b0;
    if (is_sig) begin
      pos_fin  = '0;
      set_seen = 1'b1;
      ev       = EV_SIGNAL;
      sig      = b1;
      clr1     = 1'b1;
    end else if (b1 == mac_code) begin
      if (pos_eff >= SLOT_W'(SLOTS)) begin
        pos_fin = '0;
        clr1    = 1'b1;
        if (sum == b8) begin
          ev  = EV_ADDR;
          adr = acc_addr;
        end
      end
    end else if (b1 == press_code || b1 == release_code) begin
      if (pos_eff >= SLOT_W'(3)) begin
        pos_fin = '0;
        clr1    = 1'b1;
        if (chk_ok) begin
          ev     = (b1 == press_code) ? EV_PRESS : EV_RELEASE;
          ld_rst = 1'b1;
        end
      end
    end else if (b1 == ack_code) begin
      if (pos_eff >= SLOT_W'(3)) begin
        pos_fin = '0;
        clr1    = 1'b1;
        if (chk_ok) begin
          set_seen = 1'b1;
          ev       = EV_ACK;
        end
      end
    end else if (pos_eff >= SLOT_W'(2)) begin
      pos_fin = '0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = slot_addr(ch_q, pos_cur);
    ram_wdata  = byte_q;
    ctl.clr    = 1'b0;
    ctl.take   = 1'b0;
    ctl.slot   = cnt - SLOT_W'(1);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (op == OP_BYTE && int'(channel) < CHANNELS) ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        cnt_next   = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.clr  = (cnt == '0);
        ctl.take = (cnt != '0);
        cnt_next = cnt + SLOT_W'(1);
        if ((cnt == SLOT_W'(3) && !long_mac) || cnt == SLOT_W'(SLOTS)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_next = S_IDLE;
          if (op_q == OP_BYTE && in_range_q && clr1) begin
            ram_we    = 1'b1;
            ram_waddr = slot_addr(ch_q, SLOT_W'(1));
            ram_wdata = 8'd0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      leader_byte  <= LEADER_RST;
      mac_code     <= MAC_RST;
      press_code   <= PRESS_RST;
      release_code <= RELEASE_RST;
      ack_code     <= ACK_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        write_pos[c] <= '0;
      end
      seen      <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (done_go) begin
        out_valid <= 1'b1;
        if (op_q == OP_TIMEOUT) begin
          for (int c = 0; c < CHANNELS; c++) begin
            write_pos[c] <= '0;
          end
        end else if (in_range_q) begin
          write_pos[ch_q] <= pos_fin;
          if (set_seen) begin
            seen[ch_q] <= 1'b1;
          end
          if (ld_rst) begin
            leader_byte <= LEADER_RST;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LEADER:  leader_byte  <= cfg_data;
          REG_MAC:     mac_code     <= cfg_data;
          REG_PRESS:   press_code   <= cfg_data;
          REG_RELEASE: release_code <= cfg_data;
          REG_ACK:     ack_code     <= cfg_data;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_rd <= vld[ram_raddr];
    if (accept) begin
      op_q       <= op;
      ch_q       <= channel;
      byte_q     <= rx_byte;
      in_range_q <= int'(channel) < CHANNELS;
    end
    if (state == S_WRITE) begin
      pos_q <= pos_cur + SLOT_W'(1);
    end
    if (done_go) begin
      if (op_q == OP_BYTE && in_range_q) begin
        event_res     <= ev;
        event_channel <= ch_q;
        signal_code   <= sig;
        address       <= adr;
      end else begin
        event_res     <= EV_NONE;
        event_channel <= (op_q == OP_TIMEOUT) ? 1'b0 : ch_q;
        signal_code   <= 8'd0;
        address       <= 48'd0;
      end
    end
  end

  assign selftest_flags = seen;

`ifndef ASSERT_OFF
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside final step");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_res <= EV_ACK)
    else $error("event code out of range");

  a_addr_only_mac: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_ADDR) |-> address == 48'd0)
    else $error("address on non-address event");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> write_pos[ch_q] < SLOT_W'(SLOTS))
    else $error("write position past frame end");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !ram_we)
    else $error("store written during scan");
`endif

endmodule

[verif/tb_ir_frame_parser.sv]
`timescale 1ns / 100ps

module tb_ir_frame_parser;
  import ifp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [2:0]  ev;
    logic        ch;
    logic [7:0]  sig;
    logic [47:0] addr;
    logic [1:0]  flags;
  } parser_event_t;

  typedef enum int {
    FR_SIGNAL,
    FR_MAC,
    FR_PRESS,
    FR_RELEASE,
    FR_ACK,
    FR_OTHER
  } frame_kind_t;

  class frame_scoreboard;
    logic [7:0] leader_b, mac_c, press_c, rel_c, ack_c;
    logic [7:0] store [CHANNELS][SLOTS];
    logic [3:0] wpos [CHANNELS];
    logic       seen [CHANNELS];
    parser_event_t event_q [$];
    int mismatches;

    function new();
      leader_b = LEADER_RST;
      mac_c    = MAC_RST;
      press_c  = PRESS_RST;
      rel_c    = RELEASE_RST;
      ack_c    = ACK_RST;
      foreach (store[c, s]) store[c][s] = 8'h00;
      foreach (wpos[c]) begin
        wpos[c] = '0;
        seen[c] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_LEADER:  leader_b = val;
        REG_MAC:     mac_c = val;
        REG_PRESS:   press_c = val;
        REG_RELEASE: rel_c = val;
        REG_ACK:     ack_c = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return event_q.size();
    endfunction

    function void note_input(logic o, logic c, logic [7:0] b);
      parser_event_t r;
      logic [3:0] p;
      logic [7:0] cmd, sum;
      logic [8:0] chk;
      int i;
      r = '0;
      if (o == OP_TIMEOUT) begin
        foreach (wpos[k]) wpos[k] = '0;
        r.ch = 1'b0;
      end else begin
        p = wpos[c];
        if (p >= SLOTS) p = '0;
        store[c][p] = b;
        p = p + 4'd1;
        if (store[c][0] != leader_b) p = '0;
        cmd = store[c][1];
        chk = {1'b0, cmd} + {1'b0, store[c][2]};
        if (cmd == SIG_A || cmd == SIG_B || cmd == SIG_C) begin
          p = '0;
          seen[c] = 1'b1;
          r.ev = EV_SIGNAL;
          r.sig = cmd;
          store[c][1] = 8'h00;
        end else if (cmd == mac_c) begin
          if (p >= SLOTS) begin
            p = '0;
            sum = 8'h00;
            for (i = 0; i < 8; i++) sum = sum + store[c][i];
            if (sum == store[c][8]) begin
              r.ev = EV_ADDR;
              for (i = 2; i < 8; i++) r.addr = {r.addr[39:0], store[c][i]};
            end
            store[c][1] = 8'h00;
          end
        end else if (cmd == press_c || cmd == rel_c) begin
          if (p >= 4'd3) begin
            p = '0;
            if (chk == PAIR_TOTAL) begin
              r.ev = (cmd == press_c) ? EV_PRESS : EV_RELEASE;
              leader_b = LEADER_RST;
            end
            store[c][1] = 8'h00;
          end
        end else if (cmd == ack_c) begin
          if (p >= 4'd3) begin
            p = '0;
            if (chk == PAIR_TOTAL) begin
              seen[c] = 1'b1;
              r.ev = EV_ACK;
            end
            store[c][1] = 8'h00;
          end
        end else if (p >= 4'd2) begin
          p = '0;
        end
        wpos[c] = p;
        r.ch = c;
      end
      r.flags = {seen[1], seen[0]};
      event_q.push_back(r);
    endfunction

    function void check_result(parser_event_t got);
      parser_event_t want;
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result ev=%0d ch=%0d", got.ev, got.ch);
        return;
      end
      want = event_q.pop_front();
      if (got.ev !== want.ev || got.ch !== want.ch || got.sig !== want.sig ||
          got.addr !== want.addr || got.flags !== want.flags) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp ev=%0d ch=%0d sig=%h addr=%h flags=%b",
                   want.ev, want.ch, want.sig, want.addr, want.flags);
          $display("       got ev=%0d ch=%0d sig=%h addr=%h flags=%b",
                   got.ev, got.ch, got.sig, got.addr, got.flags);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_BYTE;
  logic        channel = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic        event_channel;
  logic [7:0]  signal_code;
  logic [47:0] address;
  logic [1:0]  selftest_flags;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_LEADER;
  logic [7:0]  cfg_data = 8'h00;

  logic idle_en = 1'b1;
  int   stall_cnt = 0;
  int   items_sent = 0;
  frame_scoreboard sb;

  ir_frame_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .channel        (channel),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .event_channel  (event_channel),
    .signal_code    (signal_code),
    .address        (address),
    .selftest_flags (selftest_flags),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({event_res, event_channel, signal_code, address, selftest_flags});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_item(input logic o, input logic c, input logic [7:0] b);
    while (idle_en && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    channel  <= c;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(o, c, b);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] l, input logic [7:0] m, input logic [7:0] p,
                            input logic [7:0] r, input logic [7:0] a);
    logic [2:0] idx [5];
    logic [7:0] vals [5];
    int i;
    idx  = '{REG_LEADER, REG_MAC, REG_PRESS, REG_RELEASE, REG_ACK};
    vals = '{l, m, p, r, a};
    for (i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // builds a frame from the current codes; sometimes cut short
  task automatic send_frame(input frame_kind_t kind, input logic ch, input bit good);
    logic [7:0] fb [$];
    logic [7:0] code, s;
    int i, keep;
    fb.push_back(sb.leader_b);
    case (kind)
      FR_SIGNAL: begin
        case ($urandom_range(2))
          0: code = SIG_A;
          1: code = SIG_B;
          default: code = SIG_C;
        endcase
        fb.push_back(code);
      end
      FR_MAC: begin
        fb.push_back(sb.mac_c);
        for (i = 0; i < 6; i++) fb.push_back(8'($urandom));
        s = 8'h00;
        foreach (fb[j]) s = s + fb[j];
        fb.push_back(good ? s : 8'(s + $urandom_range(1, 255)));
      end
      FR_PRESS, FR_RELEASE, FR_ACK: begin
        code = (kind == FR_PRESS) ? sb.press_c : (kind == FR_RELEASE) ? sb.rel_c : sb.ack_c;
        fb.push_back(code);
        fb.push_back(good ? 8'(255 - code) : 8'(255 - code + $urandom_range(1, 255)));
      end
      default: fb.push_back(8'($urandom));
    endcase
    keep = fb.size();
    if ($urandom_range(9) == 0) keep = $urandom_range(1, fb.size());
    for (i = 0; i < keep; i++) send_item(OP_BYTE, ch, fb[i]);
  endtask

  initial begin
    int ph, quota;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_BYTE, 1'b0, sb.leader_b);
    send_item(OP_BYTE, 1'b0, SIG_A);
    send_item(OP_BYTE, 1'b1, sb.leader_b);
    send_item(OP_BYTE, 1'b1, SIG_B);
    send_item(OP_BYTE, 1'b0, sb.leader_b);
    send_item(OP_BYTE, 1'b0, SIG_C);
    send_frame(FR_MAC, 1'b1, 1'b1);
    send_frame(FR_PRESS, 1'b0, 1'b1);
    send_frame(FR_ACK, 1'b1, 1'b1);
    send_item(OP_BYTE, 1'b0, 8'h00);
    send_item(OP_BYTE, 1'b1, 8'hFF);
    send_item(OP_BYTE, 1'b0, sb.leader_b);
    send_item(OP_BYTE, 1'b0, 8'hFF);
    // timeout mid-frame, then slot 1 is stale on restart
    send_item(OP_BYTE, 1'b1, sb.leader_b);
    send_item(OP_BYTE, 1'b1, sb.mac_c);
    send_item(OP_TIMEOUT, 1'b1, 8'h00);
    send_item(OP_BYTE, 1'b1, sb.leader_b);
    drain();

    for (ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_config(8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE);
        2: set_config(8'hFF, SIG_A, 8'h80, 8'h80, 8'h80);
        3: set_config(8'h55, 8'h60, 8'h60, 8'h7F, 8'h7F);
        default: set_config(8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom));
      endcase
      idle_en <= (ph != 3);
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        if ($urandom_range(99) < 75)
          send_frame(frame_kind_t'($urandom_range(5)), 1'($urandom), $urandom_range(3) != 0);
        else
          send_item(($urandom_range(9) == 0) ? OP_TIMEOUT : OP_BYTE, 1'($urandom),
                    8'($urandom));
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
